// ===== rtl/core/amplim_pkg.sv =====
`default_nettype none
package amplim_pkg;

   localparam int GAIN_W          = 17;
   localparam int FRAC_W          = 16;
   localparam int RECOV_SHIFT     = 5;
   localparam int NUM_SOURCES_DEF = 4;
   localparam int SAMPLE_BITS_DEF = 16;

   // 1.0 in Q1.16
   localparam logic [GAIN_W-1:0] UNITY_GAIN = {1'b1, {FRAC_W{1'b0}}};
   // rounding term for the recovery step, 2^RECOV_SHIFT - 1
   localparam logic [GAIN_W:0] RECOV_ROUND = (GAIN_W + 1)'((1 << RECOV_SHIFT) - 1);

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/amplim_mul.sv =====
`default_nettype none
module amplim_mul #(
   parameter int A_W = amplim_pkg::SAMPLE_BITS_DEF + 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [A_W-1:0]               mcand,
   input  wire logic [amplim_pkg::GAIN_W-1:0] mplier,
   output logic [A_W-1:0]                    product,
   output amplim_pkg::unit_sts_type          sts
);
   import amplim_pkg::*;

   localparam int P_W   = A_W + GAIN_W;
   localparam int CNT_W = $clog2(GAIN_W + 1);

   logic [P_W-1:0]    acc_ff, acc_in;
   logic [P_W-1:0]    mc_ff, mc_in;
   logic [GAIN_W-1:0] mp_ff, mp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // shift-add, one multiplier bit per cycle, LSB first
   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         mc_in   = P_W'(mcand);
         mp_in   = mplier;
         cnt_in  = CNT_W'(GAIN_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   // gain <= unity, so the scaled value never outgrows the multiplicand
   assign product  = acc_ff[FRAC_W +: A_W];
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/core/amplim_div.sv =====
`default_nettype none
module amplim_div #(
   parameter int D_W = amplim_pkg::SAMPLE_BITS_DEF + 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [D_W-1:0]               num,
   input  wire logic [D_W-1:0]               den,
   output logic [amplim_pkg::FRAC_W-1:0]     quot,
   output amplim_pkg::unit_sts_type          sts
);
   import amplim_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);

   // computes (num << FRAC_W) / den for num < den, one quotient bit per cycle
   logic [D_W:0]      rem_ff, rem_in;
   logic [D_W-1:0]    den_ff, den_in;
   logic [FRAC_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [D_W:0]      shifted;
   logic [D_W:0]      diff;
   logic              fits;

   always_comb begin
      // remainder stays below den, so its top bit is always clear
      shifted = {rem_ff[D_W-1:0], 1'b0};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         q_in    = '0;
         cnt_in  = CNT_W'(FRAC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff : shifted;
         q_in   = {q_ff[FRAC_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quot     = q_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

// ===== rtl/core/audio_mix_peak_limiter_core.sv =====
`default_nettype none
// Mixer with peak limiter. Each req transfer carries NUM_SOURCES samples and a
// presence mask; the present samples are summed, scaled by the kept limiter
// gain, clamped and the gain recomputed as 1/|t| when the peak passes full
// scale, then scaled by the volume register. The gain recovers towards unity
// by a 32nd of its distance, rounded up, on every slot with a source present.
// A slot with an empty mask is taken in IDLE, gives no rsp transfer and
// leaves the gain alone. One slot is worked on at a time, by the bit-serial
// shift-add multiplier, used twice per slot, and the bit-serial reciprocal
// divider, used only when the limiter engages. The result waits in an
// output register, so the next slot is taken while it is unread.
module audio_mix_peak_limiter_core #(
   parameter int NUM_SOURCES = amplim_pkg::NUM_SOURCES_DEF,
   parameter int SAMPLE_BITS = amplim_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // source_a, source_b, ... from bit 0 up, SAMPLE_BITS each, zero padded
   input  wire logic [((NUM_SOURCES*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // present_mask, bit i for source i
   input  wire logic [NUM_SOURCES-1:0]               req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // mixed_sample from bit 0, zero padded
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]          rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [amplim_pkg::GAIN_W-1:0]        csr_wdata
);
   import amplim_pkg::*;

   localparam int SRC_W   = NUM_SOURCES * SAMPLE_BITS;
   localparam int RDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(NUM_SOURCES);
   localparam int SCNT_W  = $clog2(NUM_SOURCES + 1);

   localparam logic [SUM_W-1:0]       ONE_FS   = SUM_W'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] ONE_T    = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] ONE_T_M1 = ONE_T - 1'b1;

   typedef enum logic [2:0] {
      IDLE, SUM, MAG, MUL_LIM, DIV, RECOVER, MUL_VOL, FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [SRC_W-1:0]       src_ff, src_in;
   logic [NUM_SOURCES-1:0] mask_ff, mask_in;
   logic [SCNT_W-1:0]      scnt_ff, scnt_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0] tmag_ff, tmag_in;
   logic [SAMPLE_BITS-1:0] res_ff, res_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic [GAIN_W-1:0]      vol_ff, vol_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                   mul_start;
   logic [SUM_W-1:0]       mul_mcand;
   logic [GAIN_W-1:0]      mul_mplier;
   logic [SUM_W-1:0]       mul_product;
   unit_sts_type           mul_sts;
   logic                   div_start;
   logic [FRAC_W-1:0]      div_quot;
   unit_sts_type           div_sts;

   logic signed [SAMPLE_BITS-1:0] cur_src;
   logic [SUM_W-1:0]       mag;
   logic [GAIN_W-1:0]      vol_sat;
   logic [GAIN_W:0]        recov_step;
   logic [SAMPLE_BITS-1:0] vol_mag;

   amplim_mul #(.A_W(SUM_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .product (mul_product),
      .sts     (mul_sts)
   );

   amplim_div #(.D_W(SUM_W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (ONE_FS),
      .den     (mul_product),
      .quot    (div_quot),
      .sts     (div_sts)
   );

   assign req_tready = (state_ff == IDLE);

   always_comb begin
      cur_src    = signed'(src_ff[SAMPLE_BITS-1:0]);
      mag        = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
      vol_sat    = (vol_ff > UNITY_GAIN) ? UNITY_GAIN : vol_ff;
      recov_step = ({1'b0, UNITY_GAIN - gain_ff} + RECOV_ROUND) >> RECOV_SHIFT;
      vol_mag    = mul_product[SAMPLE_BITS-1:0];

      state_in     = state_ff;
      src_in       = src_ff;
      mask_in      = mask_ff;
      scnt_in      = scnt_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      tmag_in      = tmag_ff;
      res_in       = res_ff;
      gain_in      = gain_ff;
      vol_in       = csr_we ? csr_wdata : vol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_mcand    = mag;
      mul_mplier   = gain_ff;
      div_start    = 1'b0;

      case (state_ff)
         IDLE: begin
            if (req_tvalid && (req_tuser != '0)) begin
               src_in   = req_tdata[SRC_W-1:0];
               mask_in  = req_tuser;
               scnt_in  = SCNT_W'(NUM_SOURCES);
               sum_in   = '0;
               state_in = SUM;
            end
         end
         SUM: begin
            // one source word per cycle off the bottom of the slot register
            if (mask_ff[0]) begin
               sum_in = sum_ff + SUM_W'(cur_src);
            end
            src_in  = src_ff >> SAMPLE_BITS;
            mask_in = mask_ff >> 1;
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == SCNT_W'(1)) begin
               state_in = MAG;
            end
         end
         MAG: begin
            neg_in    = sum_ff[SUM_W-1];
            mul_start = 1'b1;
            state_in  = MUL_LIM;
         end
         MUL_LIM: begin
            if (mul_sts.done) begin
               if (mul_product > ONE_FS) begin
                  tmag_in   = neg_ff ? ONE_T : ONE_T_M1;
                  div_start = 1'b1;
                  state_in  = DIV;
               end else begin
                  // exactly +1.0 does not limit but has to fit the output
                  if (!neg_ff && (mul_product == ONE_FS)) begin
                     tmag_in = ONE_T_M1;
                  end else begin
                     tmag_in = mul_product[SAMPLE_BITS-1:0];
                  end
                  state_in = RECOVER;
               end
            end
         end
         DIV: begin
            if (div_sts.done) begin
               gain_in  = GAIN_W'(div_quot);
               state_in = RECOVER;
            end
         end
         RECOVER: begin
            if (gain_ff < UNITY_GAIN) begin
               gain_in = gain_ff + recov_step[GAIN_W-1:0];
            end
            mul_start  = 1'b1;
            mul_mcand  = SUM_W'(tmag_ff);
            mul_mplier = vol_sat;
            state_in   = MUL_VOL;
         end
         MUL_VOL: begin
            mul_mcand  = SUM_W'(tmag_ff);
            mul_mplier = vol_sat;
            if (mul_sts.done) begin
               res_in   = neg_ff ? (SAMPLE_BITS'(0) - vol_mag) : vol_mag;
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         gain_ff      <= UNITY_GAIN;
         vol_ff       <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
         scnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         vol_ff       <= vol_in;
         rsp_valid_ff <= rsp_valid_in;
         scnt_ff      <= scnt_in;
         src_ff       <= src_in;
         mask_ff      <= mask_in;
         sum_ff       <= sum_in;
         neg_ff       <= neg_in;
         tmag_ff      <= tmag_in;
         res_ff       <= res_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RDATA_W'(rsp_data_ff);

`ifndef SYNTHESIS
   a_gain_le_unity: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= UNITY_GAIN)
      else $error("limiter gain above unity");

   a_mul_done_owned: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == MUL_LIM || state_ff == MUL_VOL))
      else $error("multiplier finished outside a multiply state");

   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == DIV))
      else $error("divider finished outside the divide state");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.busy && div_sts.busy))
      else $error("multiplier and divider busy together");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == FINISH))
      else $error("result overwrote an untaken transfer");
`endif

endmodule
`default_nettype wire
